### rtl/rri2d_pkg.sv
// Shared types and constants of the 2-D ray/ray intersection pipeline.
package rri2d_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int MAG_W           = 64;
  localparam int Q_W             = 31;
  localparam int DIV_W           = MAG_W + Q_W + 1;
  localparam int IN_W            = 320;
  localparam int OUT_W           = 96;

  typedef enum logic [1:0] {
    OUT_PARALLEL = 2'd0,
    OUT_COLINEAR = 2'd1,
    OUT_HIT      = 2'd2,
    OUT_BEHIND   = 2'd3
  } outcome_t;

  typedef struct packed {
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] p1z;
    logic signed [31:0] d1x;
    logic signed [31:0] d1y;
    logic signed [31:0] d1z;
    outcome_t           outcome;
  } carry_t;

  typedef struct packed {
    outcome_t           outcome;
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } result_t;

endpackage

### rtl/ray_ray_intersect_2d_top.sv
// Top level of the 2-D ray/ray intersection pipeline.
//
// The s_ channel takes one item per ray pair: two origins and two directions
// in signed Q16.16 (the first ray also carries z). The m_ channel returns one
// item per pair: the outcome code in m_tuser and the result point in m_tdata.
// The pipeline holds 38 register stages: four for the origin difference,
// the cross products and the sign test, one divider setup stage, 31 divider
// stages that each settle one bit of t1, one multiply stage and a
// two-entry output buffer. An item accepted by s_ passes through these stages
// in order and is then offered on m_tvalid from the buffer, and one item can
// be accepted in every cycle while s_tready is high.
// When the receiver holds m_tready low the buffer takes up to two results;
// once it is full, s_tready drops and every stage holds its contents, so no
// item is lost or repeated. s_tready depends only on registered state.
// Reset empties the pipeline and the buffer; nothing else carries over
// between items.
module ray_ray_intersect_2d_top import rri2d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // ray1_origin_x, ray1_origin_y, ray1_origin_z, ray1_dir_x, ray1_dir_y,
  // ray1_dir_z, ray2_origin_x, ray2_origin_y, ray2_dir_x, ray2_dir_y
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // point_x, point_y, point_z
  output logic [OUT_W-1:0]  m_tdata,
  // outcome
  output logic [1:0]        m_tuser
);

  logic             ce;
  logic             x_valid, d_valid, p_valid;
  carry_t           x_carry, d_carry;
  logic [MAG_W-1:0] x_num, x_den;
  logic [Q_W-1:0]   d_t1;
  result_t          p_result, b_result;

  assign s_tready = ce;

  rri2d_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_valid (x_valid),
    .out_carry (x_carry),
    .out_num   (x_num),
    .out_den   (x_den)
  );

  rri2d_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (x_valid),
    .in_carry  (x_carry),
    .in_num    (x_num),
    .in_den    (x_den),
    .out_valid (d_valid),
    .out_carry (d_carry),
    .out_t1    (d_t1)
  );

  rri2d_point u_point (
    .clk        (clk),
    .rst        (rst),
    .ce         (ce),
    .in_valid   (d_valid),
    .in_carry   (d_carry),
    .in_t1      (d_t1),
    .out_valid  (p_valid),
    .out_result (p_result)
  );

  rri2d_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (p_valid && ce),
    .din       (p_result),
    .space     (ce),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (b_result)
  );

  assign m_tdata = {b_result.pz, b_result.py, b_result.px};
  assign m_tuser = b_result.outcome;

endmodule

### rtl/rri2d_cross.sv
// Front stages: origin difference, cross products, signs, magnitudes and outcome.
module rri2d_cross import rri2d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              ce,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_data,
  output logic              out_valid,
  output carry_t            out_carry,
  output logic [MAG_W-1:0]  out_num,
  output logic [MAG_W-1:0]  out_den
);

  logic               a_v, b_v, c_v;
  logic signed [31:0] a_p1x, a_p1y, a_p1z, a_d1x, a_d1y, a_d1z, a_d2x, a_d2y;
  logic signed [32:0] a_ex, a_ey;
  logic signed [31:0] b_p1x, b_p1y, b_p1z, b_d1x, b_d1y, b_d1z;
  logic signed [63:0] b_ma, b_mb;
  logic signed [64:0] b_mc, b_md, b_me, b_mf;
  logic signed [31:0] c_p1x, c_p1y, c_p1z, c_d1x, c_d1y, c_d1z;
  logic signed [64:0] c_c1;
  logic signed [65:0] c_c2, c_c3;

  logic        z1, z2, z3, ok;
  logic [64:0] mag1_full;
  logic [65:0] mag2_full;
  outcome_t    oc;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      a_v       <= in_valid;
      b_v       <= a_v;
      c_v       <= b_v;
      out_valid <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_p1x <= in_data[31:0];
      a_p1y <= in_data[63:32];
      a_p1z <= in_data[95:64];
      a_d1x <= in_data[127:96];
      a_d1y <= in_data[159:128];
      a_d1z <= in_data[191:160];
      a_d2x <= in_data[287:256];
      a_d2y <= in_data[319:288];
      a_ex  <= {in_data[223], in_data[223:192]} - {in_data[31], in_data[31:0]};
      a_ey  <= {in_data[255], in_data[255:224]} - {in_data[63], in_data[63:32]};

      b_p1x <= a_p1x;
      b_p1y <= a_p1y;
      b_p1z <= a_p1z;
      b_d1x <= a_d1x;
      b_d1y <= a_d1y;
      b_d1z <= a_d1z;
      b_ma  <= a_d1x * a_d2y;
      b_mb  <= a_d1y * a_d2x;
      b_mc  <= a_ex * a_d2y;
      b_md  <= a_ey * a_d2x;
      b_me  <= a_ex * a_d1y;
      b_mf  <= a_ey * a_d1x;

      c_p1x <= b_p1x;
      c_p1y <= b_p1y;
      c_p1z <= b_p1z;
      c_d1x <= b_d1x;
      c_d1y <= b_d1y;
      c_d1z <= b_d1z;
      c_c1  <= {b_ma[63], b_ma} - {b_mb[63], b_mb};
      c_c2  <= {b_mc[64], b_mc} - {b_md[64], b_md};
      c_c3  <= {b_me[64], b_me} - {b_mf[64], b_mf};

      out_carry.p1x     <= c_p1x;
      out_carry.p1y     <= c_p1y;
      out_carry.p1z     <= c_p1z;
      out_carry.d1x     <= c_d1x;
      out_carry.d1y     <= c_d1y;
      out_carry.d1z     <= c_d1z;
      out_carry.outcome <= oc;
      out_num           <= mag2_full[MAG_W-1:0];
      out_den           <= mag1_full[MAG_W-1:0];
    end
  end

  // Both t values are nonnegative exactly when each numerator is zero or
  // shares the sign of the common denominator.
  always_comb begin
    z1        = (c_c1 == '0);
    z2        = (c_c2 == '0);
    z3        = (c_c3 == '0);
    ok        = (z2 || (c_c2[65] == c_c1[64])) && (z3 || (c_c3[65] == c_c1[64]));
    mag1_full = c_c1[64] ? (65'd0 - c_c1) : c_c1;
    mag2_full = c_c2[65] ? (66'd0 - c_c2) : c_c2;
    if (z1) begin
      oc = z2 ? OUT_COLINEAR : OUT_PARALLEL;
    end else begin
      oc = ok ? OUT_HIT : OUT_BEHIND;
    end
  end

endmodule

### rtl/rri2d_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturating t1.
module rri2d_div import rri2d_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             ce,
  input  logic             in_valid,
  input  carry_t           in_carry,
  input  logic [MAG_W-1:0] in_num,
  input  logic [MAG_W-1:0] in_den,
  output logic             out_valid,
  output carry_t           out_carry,
  output logic [Q_W-1:0]   out_t1
);

  logic [Q_W:0]       st_v;
  logic [Q_W:0]       st_sat;
  logic [DIV_W-1:0]   st_rem [0:Q_W];
  logic [MAG_W-1:0]   st_den [0:Q_W];
  logic [Q_W-1:0]     st_q   [0:Q_W];
  carry_t             st_carry [0:Q_W];
  logic [DIV_W-1:0]   rem_next [1:Q_W];
  logic [Q_W-1:0]     q_next   [1:Q_W];

  logic [DIV_W-1:0]   init_rem, init_lim;

  assign init_rem = {{(DIV_W-MAG_W){1'b0}}, in_num} << COORD_FRAC_BITS;
  assign init_lim = {{(DIV_W-MAG_W){1'b0}}, in_den} << Q_W;

  // Stage i settles quotient bit Q_W - i by a trial subtraction.
  always_comb begin
    logic [DIV_W-1:0] trial;
    logic             ge;
    for (int i = 1; i <= Q_W; i++) begin
      trial       = {{(DIV_W-MAG_W){1'b0}}, st_den[i-1]} << (Q_W - i);
      ge          = (st_rem[i-1] >= trial);
      rem_next[i] = ge ? (st_rem[i-1] - trial) : st_rem[i-1];
      q_next[i]   = st_q[i-1] | (ge ? (Q_W'(1) << (Q_W - i)) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= '0;
    end else if (ce) begin
      st_v <= {st_v[Q_W-1:0], in_valid};
    end
  end

  // A quotient that would not fit in Q_W bits is caught up front.
  always_ff @(posedge clk) begin
    if (ce) begin
      st_rem[0]   <= init_rem;
      st_den[0]   <= in_den;
      st_q[0]     <= '0;
      st_sat      <= {st_sat[Q_W-1:0], (init_rem >= init_lim)};
      st_carry[0] <= in_carry;
      for (int i = 1; i <= Q_W; i++) begin
        st_rem[i]   <= rem_next[i];
        st_q[i]     <= q_next[i];
        st_den[i]   <= st_den[i-1];
        st_carry[i] <= st_carry[i-1];
      end
    end
  end

  assign out_valid = st_v[Q_W];
  assign out_carry = st_carry[Q_W];
  assign out_t1    = st_sat[Q_W] ? '1 : st_q[Q_W];

endmodule

### rtl/rri2d_point.sv
// Hit point stage: scale the first direction by t1, add the origin, saturate; other outcomes give the origin or zero.
module rri2d_point import rri2d_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           ce,
  input  logic           in_valid,
  input  carry_t         in_carry,
  input  logic [Q_W-1:0] in_t1,
  output logic           out_valid,
  output result_t        out_result
);

  logic               m_v;
  carry_t             m_carry;
  logic signed [63:0] m_px, m_py, m_pz;
  logic signed [31:0] t1_s;
  logic signed [31:0] hx, hy, hz;

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] org,
                                                 input logic signed [63:0] prod);
    logic signed [63:0] sh;
    logic signed [64:0] sum;
    begin
      sh  = prod >>> COORD_FRAC_BITS;
      sum = {org[31], {32{org[31]}}, org} + {sh[63], sh};
      if (sum[64:31] == '0 || sum[64:31] == '1) begin
        add_sat = sum[31:0];
      end else begin
        add_sat = sum[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
    end
  endfunction

  assign t1_s = {1'b0, in_t1};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (ce) begin
      m_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_carry <= in_carry;
      m_px    <= in_carry.d1x * t1_s;
      m_py    <= in_carry.d1y * t1_s;
      m_pz    <= in_carry.d1z * t1_s;
    end
  end

  assign hx = add_sat(m_carry.p1x, m_px);
  assign hy = add_sat(m_carry.p1y, m_py);
  assign hz = add_sat(m_carry.p1z, m_pz);

  always_comb begin
    out_valid          = m_v;
    out_result.outcome = m_carry.outcome;
    case (m_carry.outcome)
      OUT_HIT: begin
        out_result.px = hx;
        out_result.py = hy;
        out_result.pz = hz;
      end
      OUT_COLINEAR: begin
        out_result.px = m_carry.p1x;
        out_result.py = m_carry.p1y;
        out_result.pz = m_carry.p1z;
      end
      default: begin
        out_result.px = '0;
        out_result.py = '0;
        out_result.pz = '0;
      end
    endcase
  end

endmodule

### rtl/rri2d_obuf.sv
// Two-entry output buffer that decouples the pipeline from the receiver.
module rri2d_obuf import rri2d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t dout
);

  result_t    mem [0:1];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

### rtl/rri2d_checker.sv
// Port-level checker for the intersection block, bound to its top level.
module rri2d_checker import rri2d_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic [1:0]       m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == OUT_PARALLEL || m_tuser == OUT_BEHIND) |-> m_tdata == '0)
    else $error("parallel or behind result carries a nonzero point");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !$past(m_tready && m_tvalid))
    else $error("input stalled without a waiting result");

endmodule

bind ray_ray_intersect_2d_top rri2d_checker u_rri2d_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
